// ----- src/tcpu_pkg.sv -----
`default_nettype none
package tcpu_pkg;
    localparam logic [4:0] CMD_MOV = 5'd0;
    localparam logic [4:0] CMD_LOAD = 5'd1;
    localparam logic [4:0] CMD_STORE = 5'd2;
    localparam logic [4:0] CMD_ADD = 5'd3;
    localparam logic [4:0] CMD_SUB = 5'd4;
    localparam logic [4:0] CMD_MUL = 5'd5;
    localparam logic [4:0] CMD_DIV = 5'd6;
    localparam logic [4:0] CMD_INC = 5'd7;
    localparam logic [4:0] CMD_DEC = 5'd8;
    localparam logic [4:0] CMD_SHL = 5'd9;
    localparam logic [4:0] CMD_SHR = 5'd10;
    localparam logic [4:0] CMD_ROL = 5'd11;
    localparam logic [4:0] CMD_ROR = 5'd12;
    localparam logic [4:0] CMD_PUSH = 5'd13;
    localparam logic [4:0] CMD_POP = 5'd14;
    localparam logic [4:0] CMD_INPUT = 5'd15;
    localparam logic [4:0] CMD_DISPLAY = 5'd16;
    localparam logic [4:0] CMD_RESET = 5'd17;

    localparam logic [1:0] MODE_IMM = 2'd0;
    localparam logic [1:0] MODE_REG = 2'd1;
    localparam logic [1:0] MODE_IND = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_DIV0 = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_SOVF = 3'd3;
    localparam logic [2:0] ST_SUNF = 3'd4;
    localparam logic [2:0] ST_UNK = 3'd5;
    localparam logic [2:0] ST_HALT = 3'd6;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [2:0]  dest_reg;
        logic [2:0]  src_reg;
        logic [1:0]  src_mode;
        logic [15:0] immediate;
        logic [7:0]  mem_address;
    } t_instr;
endpackage
`default_nettype wire

// ----- src/tcpu_front.sv -----
`default_nettype none
// Accepts requests and holds them in a two-entry queue for the back end.
module tcpu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire tcpu_pkg::t_instr i_instr,
    output logic                 o_q_valid,
    output tcpu_pkg::t_instr     o_q_instr,
    input  wire logic            i_q_pop
);
    import tcpu_pkg::*;
    t_instr     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_instr = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_instr;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

// ----- src/tcpu_back.sv -----
`default_nettype none
// Executes one queued instruction at a time. Memory reads are registered,
// division runs one quotient bit per cycle.
module tcpu_back #(
    parameter int MEM_DEPTH = 64,
    parameter int STACK_DEPTH = 64,
    parameter int REG_COUNT = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire tcpu_pkg::t_instr i_q_instr,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [2:0]            o_status,
    output logic signed [7:0]     o_display_value,
    output logic                  o_overflow_flag,
    output logic                  o_underflow_flag,
    output logic                  o_carry_flag,
    output logic                  o_zero_flag,
    output logic [7:0]            o_program_counter,
    output logic [6:0]            o_stack_count
);
    import tcpu_pkg::*;
    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state;
    t_instr      r_ins;
    logic [7:0]  r_rf [REG_COUNT];
    logic [7:0]  r_dmem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_dval;
    logic [7:0]  r_smem [STACK_DEPTH];
    logic [7:0]  r_dq;
    logic [7:0]  r_sq;
    logic [3:0]  r_flags;
    logic [7:0]  r_pc;
    logic [8:0]  r_sp;
    logic        r_halt;
    logic [2:0]  r_status;
    logic [7:0]  r_disp;
    logic [16:0] r_raw;
    logic        r_wr;
    logic [7:0]  r_div_rem;
    logic [7:0]  r_div_quo;
    logic [7:0]  r_div_dvs;
    logic [3:0]  r_div_cnt;
    logic        r_div_neg;
    logic        r_out_valid;

    logic [RIW-1:0] d_idx, s_idx;
    logic [7:0]     vd, vs;
    logic [7:0]     ind_addr;
    logic [7:0]     eff_addr;
    logic           addr_ok, st_addr_ok;
    logic [16:0]    raw;
    logic [8:0]     rem_sh;
    logic [2:0]     sh;
    logic [15:0]    rot;
    logic [8:0]     sp_dec;

    function automatic logic [RIW-1:0] f_ridx(input logic [2:0] f);
        logic [4:0] m;
        m = {2'b00, f};
        for (int k = 0; k < 3; k++) begin
            if (m >= 5'(REG_COUNT)) m = m - 5'(REG_COUNT);
        end
        return m[RIW-1:0];
    endfunction

    function automatic logic [3:0] f_flags(input logic [16:0] v);
        logic signed [16:0] s;
        s = signed'(v);
        return {s == 0, (s > 255) || (s < -256), s < -128, s > 127};
    endfunction

    assign d_idx = f_ridx(r_ins.dest_reg);
    assign s_idx = f_ridx(r_ins.src_reg);
    assign vd = r_rf[d_idx];
    assign vs = r_rf[s_idx];
    assign ind_addr = vs;
    assign eff_addr = (r_ins.src_mode == MODE_IND) ? ind_addr : r_ins.mem_address;
    assign addr_ok = ({1'b0, eff_addr} < 9'(MEM_DEPTH));
    assign st_addr_ok = ({1'b0, r_ins.mem_address} < 9'(MEM_DEPTH));
    assign sh = r_ins.immediate[2:0];
    assign rot = {vd, vd};
    assign rem_sh = {r_div_rem, r_div_quo[7]};
    assign sp_dec = r_sp - 9'd1;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && !r_out_valid;

    always_comb begin
        raw = '0;
        case (r_ins.cmd)
            CMD_ADD: raw = 17'(signed'(vd)) + 17'(signed'(vs));
            CMD_SUB: raw = 17'(signed'(vd)) - 17'(signed'(vs));
            CMD_MUL: raw = 17'(signed'(vd) * signed'(vs));
            CMD_INC: raw = 17'(signed'(vd)) + 17'd1;
            CMD_DEC: raw = 17'(signed'(vd)) - 17'd1;
            CMD_SHL: raw = 17'(signed'(8'(vd << sh)));
            CMD_SHR: raw = 17'(signed'(8'(vd >> sh)));
            CMD_ROL: raw = 17'(signed'(rot[15 - {1'b0, sh} -: 8]));
            CMD_ROR: raw = 17'(signed'(rot[7 + {1'b0, sh} -: 8]));
            CMD_INPUT: raw = 17'(signed'(r_ins.immediate));
            CMD_MOV: raw = (r_ins.src_mode == MODE_IMM)
                ? 17'(signed'(r_ins.immediate)) : 17'(signed'(vs));
            default: raw = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // Reads are issued while the request is decoded, so the data is ready
        // for the write-back cycle. Entries not stored since reset read as zero.
        if (r_state == S_READ) begin
            r_dq <= r_dval[eff_addr[MAW-1:0]] ? r_dmem[eff_addr[MAW-1:0]] : 8'd0;
        end
        if (r_state == S_READ && r_ins.cmd == CMD_POP) begin
            r_sq <= r_smem[sp_dec[SAW-1:0]];
        end
        if (r_state == S_IDLE && o_q_pop) r_ins <= i_q_instr;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flags <= '0;
            r_pc <= '0;
            r_sp <= '0;
            r_halt <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr <= 1'b0;
            r_dval <= '0;
            for (int i = 0; i < REG_COUNT; i++) r_rf[i] <= '0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) r_state <= S_READ;
                end
                S_READ: begin
                    r_status <= ST_OK;
                    r_disp <= '0;
                    r_wr <= 1'b0;
                    r_state <= S_OUT;
                    if (r_halt) begin
                        r_status <= ST_HALT;
                    end else begin
                        r_pc <= r_pc + 8'd1;
                        case (r_ins.cmd)
                            CMD_MOV, CMD_LOAD: begin
                                if (r_ins.src_mode == MODE_IMM ||
                                        r_ins.src_mode == MODE_REG) begin
                                    if (r_ins.cmd == CMD_MOV) begin
                                        r_rf[d_idx] <= raw[7:0];
                                        r_flags <= f_flags(raw);
                                    end
                                end else if (!addr_ok) begin
                                    r_status <= ST_ADDR;
                                end else begin
                                    r_state <= S_WB;
                                end
                            end
                            CMD_STORE: begin
                                if (!st_addr_ok) begin
                                    r_status <= ST_ADDR;
                                end else begin
                                    r_dmem[r_ins.mem_address[MAW-1:0]] <=
                                        (r_ins.src_mode == MODE_IMM)
                                        ? r_ins.immediate[7:0] : vs;
                                    r_dval[r_ins.mem_address[MAW-1:0]] <= 1'b1;
                                end
                            end
                            CMD_DIV: begin
                                if (vs == 8'd0) begin
                                    r_status <= ST_DIV0;
                                end else begin
                                    r_div_rem <= '0;
                                    r_div_quo <= vd[7] ? 8'(-vd) : vd;
                                    r_div_dvs <= vs[7] ? 8'(-vs) : vs;
                                    r_div_neg <= vd[7] ^ vs[7];
                                    r_div_cnt <= 4'd8;
                                    r_state <= S_DIV;
                                end
                            end
                            CMD_ADD, CMD_SUB, CMD_MUL, CMD_INC, CMD_DEC, CMD_SHL,
                            CMD_SHR, CMD_ROL, CMD_ROR, CMD_INPUT: begin
                                r_rf[d_idx] <= raw[7:0];
                                r_flags <= f_flags(raw);
                            end
                            CMD_PUSH: begin
                                if (r_sp >= 9'(STACK_DEPTH)) begin
                                    r_status <= ST_SOVF;
                                    r_halt <= 1'b1;
                                    r_pc <= r_pc;
                                end else begin
                                    r_smem[r_sp[SAW-1:0]] <= vd;
                                    r_sp <= r_sp + 9'd1;
                                end
                            end
                            CMD_POP: begin
                                if (r_sp == 9'd0) begin
                                    r_status <= ST_SUNF;
                                    r_halt <= 1'b1;
                                    r_pc <= r_pc;
                                end else begin
                                    r_sp <= sp_dec;
                                    r_wr <= 1'b1;
                                    r_state <= S_WB;
                                end
                            end
                            CMD_DISPLAY: r_disp <= vd;
                            CMD_RESET: begin
                                for (int i = 0; i < REG_COUNT; i++) r_rf[i] <= '0;
                                r_flags <= '0;
                            end
                            default: r_status <= ST_UNK;
                        endcase
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (r_div_cnt == 4'd0) begin
                        r_raw <= r_div_neg ? 17'(-{9'd0, r_div_quo})
                                           : {9'd0, r_div_quo};
                        r_rf[d_idx] <= r_div_neg ? 8'(-r_div_quo) : r_div_quo;
                        r_flags <= f_flags(r_div_neg ? 17'(-{9'd0, r_div_quo})
                                                     : {9'd0, r_div_quo});
                        r_state <= S_OUT;
                    end else begin
                        r_div_cnt <= r_div_cnt - 4'd1;
                        if (rem_sh >= {1'b0, r_div_dvs}) begin
                            r_div_rem <= 8'(rem_sh - {1'b0, r_div_dvs});
                            r_div_quo <= {r_div_quo[6:0], 1'b1};
                        end else begin
                            r_div_rem <= rem_sh[7:0];
                            r_div_quo <= {r_div_quo[6:0], 1'b0};
                        end
                    end
                end
                S_WB: begin
                    if (r_wr) begin
                        r_rf[d_idx] <= r_sq;
                        r_flags <= f_flags(17'(signed'(r_sq)));
                    end else begin
                        r_rf[d_idx] <= r_dq;
                        r_flags <= f_flags(17'(signed'(r_dq)));
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_status;
    assign o_display_value = r_disp;
    assign o_overflow_flag = r_flags[0];
    assign o_underflow_flag = r_flags[1];
    assign o_carry_flag = r_flags[2];
    assign o_zero_flag = r_flags[3];
    assign o_program_counter = r_pc;
    assign o_stack_count = r_sp[6:0];
    logic unused;
    assign unused = ^r_raw;
endmodule
`default_nettype wire

// ----- src/toy_cpu_execute_unit.sv -----
`default_nettype none
// Execute unit of a small 8-bit machine, one decoded instruction per request.
// Input channel: i_valid with the instruction fields, o_stall back to the sender.
// Output channel: o_valid with status, display value, flags, program counter
// and stack count; the receiver holds i_out_stall high to stall it.
// Requests enter a two-entry queue, so the sender may run ahead of execution.
// Most requests pass through a read and an output state; memory loads and
// POP add a write-back state, and DIV the bit-serial divider. One request
// executes at a time.
// The next request starts only once the previous result has been taken, so a
// stalled receiver backs the queue up and then stalls the sender.
// Reset clears registers, flags, program counter, stack depth and halt, and
// the data memory reads as zero until each byte is stored again.
// A stack overflow or underflow halts the unit; afterwards every request
// reports halted until reset.
module toy_cpu_execute_unit #(
    parameter int MEM_DEPTH = 64,
    parameter int STACK_DEPTH = 64,
    parameter int REG_COUNT = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [4:0]        i_cmd,
    input  wire logic [2:0]        i_dest_reg,
    input  wire logic [2:0]        i_src_reg,
    input  wire logic [1:0]        i_src_mode,
    input  wire logic signed [15:0] i_immediate,
    input  wire logic [7:0]        i_mem_address,
    output logic                   o_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_status,
    output logic signed [7:0]      o_display_value,
    output logic                   o_overflow_flag,
    output logic                   o_underflow_flag,
    output logic                   o_carry_flag,
    output logic                   o_zero_flag,
    output logic [7:0]             o_program_counter,
    output logic [6:0]             o_stack_count
);
    import tcpu_pkg::*;
    t_instr in_instr, q_instr;
    logic   q_valid, q_pop;

    assign in_instr = '{cmd: i_cmd, dest_reg: i_dest_reg, src_reg: i_src_reg,
        src_mode: i_src_mode, immediate: i_immediate, mem_address: i_mem_address};

    tcpu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_instr(in_instr), .o_q_valid(q_valid), .o_q_instr(q_instr),
        .i_q_pop(q_pop)
    );

    tcpu_back #(.MEM_DEPTH(MEM_DEPTH), .STACK_DEPTH(STACK_DEPTH),
                .REG_COUNT(REG_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid),
        .i_q_instr(q_instr), .o_q_pop(q_pop), .o_valid(o_valid),
        .i_stall(i_out_stall), .o_status(o_status),
        .o_display_value(o_display_value), .o_overflow_flag(o_overflow_flag),
        .o_underflow_flag(o_underflow_flag), .o_carry_flag(o_carry_flag),
        .o_zero_flag(o_zero_flag), .o_program_counter(o_program_counter),
        .o_stack_count(o_stack_count)
    );
endmodule
`default_nettype wire

// ----- src/tcpu_checker.sv -----
`default_nettype none
module tcpu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_status,
    input wire logic [7:0] o_display_value,
    input wire logic [6:0] o_stack_count
);
    import tcpu_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_out_stall |=> o_valid && $stable(o_status))
        else $error("stalled result changed");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_HALT)
        else $error("bad status");
    a_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_display_value == 8'd0)
        else $error("display on error");
    a_stk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stack_count <= 7'd64)
        else $error("stack count too large");
endmodule
bind toy_cpu_execute_unit tcpu_checker u_chk (.*);
`default_nettype wire

// ----- tb/tb_toy_cpu_execute_unit.sv -----
`timescale 1ns / 100ps
module tb_toy_cpu_execute_unit;
    import tcpu_pkg::*;

    localparam int MEM_SIZE = 64;
    localparam int STACK_SIZE = 64;
    localparam logic [4:0] CMD_UNKNOWN = 5'd18;
    localparam logic [4:0] CMD_UNKNOWN_TOP = 5'd31;
    localparam logic [1:0] MODE_DIR = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_FROM = 800;
    localparam int QUIET_TO = 1600;
    localparam int HOLD_FROM = 2200;
    localparam int HOLD_TO = 2500;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  disp;
        logic        ovf;
        logic        unf;
        logic        cry;
        logic        zro;
        logic [7:0]  pc;
        logic [6:0]  depth;
    } t_outcome;

    typedef struct {
        t_instr   ins;
        bit       typed;
        t_outcome want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [4:0] i_cmd = '0;
    logic [2:0] i_dest_reg = '0;
    logic [2:0] i_src_reg = '0;
    logic [1:0] i_src_mode = '0;
    logic signed [15:0] i_immediate = '0;
    logic [7:0] i_mem_address = '0;
    logic o_valid;
    logic i_out_stall = 1'b0;
    logic [2:0] o_status;
    logic signed [7:0] o_display_value;
    logic o_overflow_flag, o_underflow_flag, o_carry_flag, o_zero_flag;
    logic [7:0] o_program_counter;
    logic [6:0] o_stack_count;

    toy_cpu_execute_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_dest_reg(i_dest_reg), .i_src_reg(i_src_reg),
        .i_src_mode(i_src_mode), .i_immediate(i_immediate),
        .i_mem_address(i_mem_address), .o_valid(o_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_display_value(o_display_value),
        .o_overflow_flag(o_overflow_flag), .o_underflow_flag(o_underflow_flag),
        .o_carry_flag(o_carry_flag), .o_zero_flag(o_zero_flag),
        .o_program_counter(o_program_counter), .o_stack_count(o_stack_count)
    );

    always #1 i_clk = ~i_clk;

    // Machine state as the execute unit should hold it.
    logic [7:0] regs [8];
    logic [3:0] flags;
    logic [7:0] pc_now;
    logic [7:0] dmem [MEM_SIZE];
    logic [7:0] stk [STACK_SIZE];
    int         sp;
    bit         is_halted;

    t_outcome pending_results[$];
    int cycle_count = 0;
    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int status_hits [8];

    function automatic t_outcome execute_instr(t_instr it);
        int raw;
        int a;
        int n;
        bit wr;
        bit adv;
        logic [7:0] v;
        logic [7:0] r;
        logic [2:0] d;
        logic [2:0] s;
        t_outcome res;
        res = '0;
        wr = 0;
        adv = 1;
        raw = 0;
        d = it.dest_reg;
        s = it.src_reg;
        if (is_halted) begin
            res.status = ST_HALT;
            adv = 0;
        end else begin
            case (it.cmd)
                CMD_MOV, CMD_LOAD: begin
                    if (it.src_mode == MODE_IMM || it.src_mode == MODE_REG) begin
                        if (it.cmd == CMD_MOV) begin
                            wr = 1;
                            raw = (it.src_mode == MODE_IMM) ? int'($signed(it.immediate))
                                                            : int'($signed(regs[s]));
                        end
                    end else begin
                        a = (it.src_mode == MODE_IND) ? int'(regs[s]) : int'(it.mem_address);
                        if (a >= MEM_SIZE) res.status = ST_ADDR;
                        else begin
                            wr = 1;
                            raw = int'($signed(dmem[a]));
                        end
                    end
                end
                CMD_STORE: begin
                    if (it.mem_address >= MEM_SIZE) res.status = ST_ADDR;
                    else dmem[it.mem_address] = (it.src_mode == MODE_IMM)
                        ? it.immediate[7:0] : regs[s];
                end
                CMD_ADD: begin wr = 1; raw = int'($signed(regs[d])) + int'($signed(regs[s])); end
                CMD_SUB: begin wr = 1; raw = int'($signed(regs[d])) - int'($signed(regs[s])); end
                CMD_MUL: begin wr = 1; raw = int'($signed(regs[d])) * int'($signed(regs[s])); end
                CMD_DIV: begin
                    if (regs[s] == 8'd0) res.status = ST_DIV0;
                    else begin
                        wr = 1;
                        raw = int'($signed(regs[d])) / int'($signed(regs[s]));
                    end
                end
                CMD_INC: begin wr = 1; raw = int'($signed(regs[d])) + 1; end
                CMD_DEC: begin wr = 1; raw = int'($signed(regs[d])) - 1; end
                CMD_SHL, CMD_SHR, CMD_ROL, CMD_ROR: begin
                    v = regs[d];
                    n = int'(it.immediate[2:0]);
                    r = v;
                    if (n != 0) begin
                        if (it.cmd == CMD_SHL) r = v << n;
                        else if (it.cmd == CMD_SHR) r = v >> n;
                        else if (it.cmd == CMD_ROL) r = (v << n) | (v >> (8 - n));
                        else r = (v >> n) | (v << (8 - n));
                    end
                    wr = 1;
                    raw = int'($signed(r));
                end
                CMD_PUSH: begin
                    if (sp >= STACK_SIZE) begin
                        res.status = ST_SOVF;
                        is_halted = 1;
                        adv = 0;
                    end else begin
                        stk[sp] = regs[d];
                        sp++;
                    end
                end
                CMD_POP: begin
                    if (sp == 0) begin
                        res.status = ST_SUNF;
                        is_halted = 1;
                        adv = 0;
                    end else begin
                        sp--;
                        wr = 1;
                        raw = int'($signed(stk[sp]));
                    end
                end
                CMD_INPUT: begin wr = 1; raw = int'($signed(it.immediate)); end
                CMD_DISPLAY: res.disp = regs[d];
                CMD_RESET: begin
                    foreach (regs[i]) regs[i] = '0;
                    flags = '0;
                end
                default: res.status = ST_UNK;
            endcase
        end
        if (wr) begin
            flags[0] = raw > 127;
            flags[1] = raw < -128;
            flags[2] = raw > 255 || raw < -256;
            flags[3] = raw == 0;
            regs[d] = raw[7:0];
        end
        if (adv) pc_now = pc_now + 8'd1;
        res.ovf = flags[0];
        res.unf = flags[1];
        res.cry = flags[2];
        res.zro = flags[3];
        res.pc = pc_now;
        res.depth = sp[6:0];
        return res;
    endfunction

    function automatic bit quiet_now();
        return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    endfunction

    task automatic send_request(t_instr it, bit typed, t_outcome want);
        t_outcome got;
        @(negedge i_clk);
        if (!quiet_now() && $urandom_range(99) < 18) begin
            i_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_cmd = it.cmd;
        i_dest_reg = it.dest_reg;
        i_src_reg = it.src_reg;
        i_src_mode = it.src_mode;
        i_immediate = it.immediate;
        i_mem_address = it.mem_address;
        i_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        got = execute_instr(it);
        pending_results.push_back(typed ? want : got);
        requests_sent++;
    endtask

    function automatic t_instr random_instr();
        t_instr it;
        int pick;
        it.dest_reg = 3'($urandom);
        it.src_reg = 3'($urandom);
        it.src_mode = 2'($urandom);
        pick = $urandom_range(99);
        if (pick < 8) it.immediate = 16'sh7FFF;
        else if (pick < 16) it.immediate = -16'sh8000;
        else if (pick < 60) it.immediate = 16'($signed($urandom_range(300)) - 150);
        else it.immediate = 16'($urandom);
        it.mem_address = ($urandom_range(99) < 80) ? 8'($urandom_range(MEM_SIZE - 1))
                                                   : 8'($urandom);
        it.cmd = ($urandom_range(99) < 6) ? 5'($urandom_range(31, 18))
                                          : 5'($urandom_range(17));
        // Keep the stack in bounds here; the halting case is run at the end.
        if (it.cmd == CMD_POP && sp == 0) it.cmd = CMD_PUSH;
        if (it.cmd == CMD_PUSH && sp >= STACK_SIZE) it.cmd = CMD_POP;
        return it;
    endfunction

    function automatic t_instr mk(logic [4:0] c, logic [2:0] d, logic [2:0] s,
                                  logic [1:0] m, logic [15:0] imm, logic [7:0] adr);
        t_instr it;
        it.cmd = c;
        it.dest_reg = d;
        it.src_reg = s;
        it.src_mode = m;
        it.immediate = imm;
        it.mem_address = adr;
        return it;
    endfunction

    function automatic t_outcome mo(logic [2:0] st, logic [7:0] dv, logic [3:0] fl,
                                    logic [7:0] pc);
        t_outcome o;
        o.status = st;
        o.disp = dv;
        o.ovf = fl[0];
        o.unf = fl[1];
        o.cry = fl[2];
        o.zro = fl[3];
        o.pc = pc;
        o.depth = '0;
        return o;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver side, with one long hold-off to fill the unit up.
    always @(negedge i_clk) begin
        if (cycle_count >= HOLD_FROM && cycle_count < HOLD_TO) i_out_stall <= 1'b1;
        else if (quiet_now()) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < 18);
    end

    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending");
                errors++;
            end else begin
                w = pending_results.pop_front();
                status_hits[w.status]++;
                if (o_status !== w.status) begin
                    $error("status exp %0d got %0d", w.status, o_status); errors++;
                end
                if (o_display_value !== w.disp) begin
                    $error("display_value exp %0d got %0d", $signed(w.disp),
                           o_display_value); errors++;
                end
                if (o_overflow_flag !== w.ovf) begin
                    $error("overflow_flag exp %0d got %0d", w.ovf, o_overflow_flag); errors++;
                end
                if (o_underflow_flag !== w.unf) begin
                    $error("underflow_flag exp %0d got %0d", w.unf, o_underflow_flag); errors++;
                end
                if (o_carry_flag !== w.cry) begin
                    $error("carry_flag exp %0d got %0d", w.cry, o_carry_flag); errors++;
                end
                if (o_zero_flag !== w.zro) begin
                    $error("zero_flag exp %0d got %0d", w.zro, o_zero_flag); errors++;
                end
                if (o_program_counter !== w.pc) begin
                    $error("program_counter exp %0d got %0d", w.pc, o_program_counter);
                    errors++;
                end
                if (o_stack_count !== w.depth) begin
                    $error("stack_count exp %0d got %0d", w.depth, o_stack_count); errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_outcome none;
        int drain;
        none = '0;
        foreach (regs[i]) regs[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        foreach (stk[i]) stk[i] = '0;
        foreach (status_hits[i]) status_hits[i] = 0;
        flags = '0;
        pc_now = '0;
        sp = 0;
        is_halted = 0;

        // Rows with a typed result come straight after reset, where the state is plain.
        rows.push_back('{mk(CMD_DISPLAY, 0, 0, MODE_IMM, 0, 0), 1, mo(ST_OK, 0, 4'b0000, 1)});
        rows.push_back('{mk(CMD_INPUT, 1, 0, MODE_IMM, 16'h7FFF, 0), 1,
                         mo(ST_OK, 0, 4'b0101, 2)});
        rows.push_back('{mk(CMD_INPUT, 2, 0, MODE_IMM, 16'h8000, 0), 1,
                         mo(ST_OK, 0, 4'b0110, 3)});
        rows.push_back('{mk(CMD_INPUT, 3, 0, MODE_IMM, 0, 0), 1, mo(ST_OK, 0, 4'b1000, 4)});
        rows.push_back('{mk(CMD_DISPLAY, 1, 0, MODE_IMM, 0, 0), 1,
                         mo(ST_OK, 8'hFF, 4'b1000, 5)});
        rows.push_back('{mk(CMD_LOAD, 4, 0, MODE_DIR, 0, 8'hFF), 1,
                         mo(ST_ADDR, 0, 4'b1000, 6)});
        rows.push_back('{mk(CMD_STORE, 0, 1, MODE_REG, 0, 8'd64), 1,
                         mo(ST_ADDR, 0, 4'b1000, 7)});
        rows.push_back('{mk(CMD_LOAD, 4, 0, MODE_DIR, 0, 8'd5), 1,
                         mo(ST_OK, 0, 4'b1000, 8)});
        rows.push_back('{mk(CMD_INPUT, 5, 0, MODE_IMM, 0, 0), 1, mo(ST_OK, 0, 4'b1000, 9)});
        rows.push_back('{mk(CMD_DIV, 4, 5, MODE_REG, 0, 0), 1, mo(ST_DIV0, 0, 4'b1000, 10)});
        rows.push_back('{mk(CMD_UNKNOWN, 0, 0, MODE_IMM, 0, 0), 1, mo(ST_UNK, 0, 4'b1000, 11)});
        rows.push_back('{mk(CMD_UNKNOWN_TOP, 7, 7, MODE_DIR, 16'hFFFF, 8'hFF), 1,
                         mo(ST_UNK, 0, 4'b1000, 12)});
        // The rest are worked out by the predictor.
        rows.push_back('{mk(CMD_INPUT, 6, 0, MODE_IMM, 16'hFF80, 0), 0, none});
        rows.push_back('{mk(CMD_INPUT, 7, 0, MODE_IMM, 16'hFFFF, 0), 0, none});
        rows.push_back('{mk(CMD_DIV, 6, 7, MODE_REG, 0, 0), 0, none});
        rows.push_back('{mk(CMD_MUL, 6, 6, MODE_REG, 0, 0), 0, none});
        rows.push_back('{mk(CMD_STORE, 0, 0, MODE_IMM, 16'h1281, 8'd63), 0, none});
        rows.push_back('{mk(CMD_MOV, 0, 0, MODE_DIR, 0, 8'd63), 0, none});
        rows.push_back('{mk(CMD_STORE, 0, 7, MODE_IND, 0, 8'd2), 0, none});
        rows.push_back('{mk(CMD_INPUT, 3, 0, MODE_IMM, 16'd2, 0), 0, none});
        rows.push_back('{mk(CMD_LOAD, 1, 3, MODE_IND, 0, 0), 0, none});
        rows.push_back('{mk(CMD_ROL, 0, 0, MODE_IMM, 16'd9, 0), 0, none});
        rows.push_back('{mk(CMD_ROR, 0, 0, MODE_IMM, 16'd3, 0), 0, none});
        rows.push_back('{mk(CMD_SHL, 0, 0, MODE_IMM, 16'd7, 0), 0, none});
        rows.push_back('{mk(CMD_SHR, 0, 0, MODE_IMM, 16'd1, 0), 0, none});
        rows.push_back('{mk(CMD_PUSH, 7, 0, MODE_IMM, 0, 0), 0, none});
        rows.push_back('{mk(CMD_POP, 2, 0, MODE_IMM, 0, 0), 0, none});
        rows.push_back('{mk(CMD_ADD, 2, 2, MODE_REG, 0, 0), 0, none});
        rows.push_back('{mk(CMD_SUB, 1, 6, MODE_REG, 0, 0), 0, none});
        rows.push_back('{mk(CMD_INC, 3, 0, MODE_IMM, 0, 0), 0, none});
        rows.push_back('{mk(CMD_DEC, 5, 0, MODE_IMM, 0, 0), 0, none});
        rows.push_back('{mk(CMD_RESET, 0, 0, MODE_IMM, 0, 0), 0, none});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_request(rows[i].ins, rows[i].typed, rows[i].want);
        repeat (800) send_request(random_instr(), 0, none);

        // Fill the stack to the top, then overflow it and see the unit stay halted.
        while (sp < STACK_SIZE)
            send_request(mk(CMD_PUSH, 3'($urandom), 0, MODE_IMM, 0, 0), 0, none);
        send_request(mk(CMD_PUSH, 0, 0, MODE_IMM, 0, 0), 0, none);
        send_request(mk(CMD_RESET, 0, 0, MODE_IMM, 0, 0), 0, none);
        send_request(mk(CMD_POP, 1, 0, MODE_IMM, 0, 0), 0, none);
        send_request(random_instr(), 0, none);

        @(negedge i_clk);
        i_valid = 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("%0d requests sent, %0d results checked, with a long receiver hold-off",
                 requests_sent, results_seen);
        $display("status counts ok/div0/addr/ovf/unf/unk/halt: %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6]);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
